// ===== hw/rtl/sgs_pkg.sv =====
// Shared types, widths and constants of the Sobel gradient stream.
// No dependencies; every other file but sgs_ram imports this package.
package sgs_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int MAX_HEIGHT        = 4096;

  localparam int PIXEL_W        = 8;
  localparam int GRAD_W         = 8;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int ROW_W          = 12;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 13;

  // Weighted row/column sums reach 4*255, their difference needs a sign bit.
  localparam int WSUM_W = 10;
  localparam int SUM_W  = 11;

  // Divide by six as multiply by 683 / 4096; exact for magnitudes up to 1020.
  localparam int                RECIP_W     = 10;
  localparam logic [RECIP_W-1:0] RECIP_6    = 10'd683;
  localparam int                RECIP_SHIFT = 12;
  localparam int                PROD_W      = WSUM_W + RECIP_W;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // One window column, top to bottom.
  typedef struct packed {
    logic [PIXEL_W-1:0] top;
    logic [PIXEL_W-1:0] mid;
    logic [PIXEL_W-1:0] bot;
  } col_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] vert;
    logic signed [SUM_W-1:0] horiz;
  } sums_t;

  // |s / 6| with truncation toward zero, equal to |s| / 6.
  function automatic logic [GRAD_W-1:0] grad_scale(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0]  neg;
    logic [WSUM_W-1:0] mag;
    logic [PROD_W-1:0] prod;
    neg  = SUM_W'(-s);
    mag  = s[SUM_W-1] ? neg[WSUM_W-1:0] : s[WSUM_W-1:0];
    prod = PROD_W'(mag) * PROD_W'(RECIP_6);
    return prod[RECIP_SHIFT +: GRAD_W];
  endfunction

endpackage

// ===== hw/rtl/sgs_pixel_if.sv =====
// Pixel input channel: valid/ready handshake with one gray pixel per beat.
// Depends on sgs_pkg.
interface sgs_pixel_if;
  import sgs_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== hw/rtl/sgs_result_if.sv =====
// Result output channel: valid/ready handshake with both gradients per beat.
// Depends on sgs_pkg.
interface sgs_result_if;
  import sgs_pkg::*;

  logic              valid;
  logic              ready;
  logic [GRAD_W-1:0] grad_vertical;
  logic [GRAD_W-1:0] grad_horizontal;
  logic [GRAD_W-1:0] edge_sum;
  logic              frame_last;

  modport source (output valid, output grad_vertical, output grad_horizontal,
                  output edge_sum, output frame_last, input ready);
  modport sink   (input valid, input grad_vertical, input grad_horizontal,
                  input edge_sum, input frame_last, output ready);
endinterface

// ===== hw/rtl/sgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module sgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sgs_window.sv =====
// 3x3 pixel window: holds two columns, shifts in a new one, and gives the
// Sobel sums of the window as it stands after the shift. Depends on sgs_pkg.
module sgs_window (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  sgs_pkg::col_t col_in,
  output sgs_pkg::sums_t sums
);
  import sgs_pkg::*;

  col_t win_left;
  col_t win_mid;

  function automatic logic [WSUM_W-1:0] wsum(input logic [PIXEL_W-1:0] a,
                                             input logic [PIXEL_W-1:0] b,
                                             input logic [PIXEL_W-1:0] c);
    return WSUM_W'(a) + WSUM_W'({b, 1'b0}) + WSUM_W'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left <= '0;
      win_mid  <= '0;
    end else if (shift) begin
      win_left <= win_mid;
      win_mid  <= col_in;
    end
  end

  // Window after the shift: left = win_left, center = win_mid, right = the
  // incoming column.
  logic [WSUM_W-1:0] top_row;
  logic [WSUM_W-1:0] bot_row;
  logic [WSUM_W-1:0] left_col;
  logic [WSUM_W-1:0] right_col;

  always_comb begin
    top_row   = wsum(win_left.top, win_mid.top, col_in.top);
    bot_row   = wsum(win_left.bot, win_mid.bot, col_in.bot);
    left_col  = wsum(win_left.top, win_left.mid, win_left.bot);
    right_col = wsum(col_in.top, col_in.mid, col_in.bot);
    sums.vert  = $signed({1'b0, bot_row}) - $signed({1'b0, top_row});
    sums.horiz = $signed({1'b0, right_col}) - $signed({1'b0, left_col});
  end

endmodule

// ===== hw/rtl/sobel_gradient_stream.sv =====
// Sobel gradient stream: 3x3 vertical/horizontal gradients on a raster pixel stream.
// Pipeline: stage 1, stage 2, output register. Throughput is one pixel per clock while
// the output is not stalled, set by one read and one write per line memory.
// Reset: counters and pipeline valids clear, width 640, height 480; line memories
// are not cleared (every read they serve in a frame follows its write).
// Depends on sgs_pkg, sgs_pixel_if, sgs_result_if, sgs_ram, sgs_window.
module sobel_gradient_stream #(
  parameter int MAX_WIDTH = sgs_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  sgs_pixel_if.sink                      pixels,
  sgs_result_if.source                   results,
  input  logic                           cfg_wr_en,
  input  logic [sgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sgs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sgs_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  // ---------------------------------------------------------------------------
  // Configuration registers. Any write restarts the frame.
  // ---------------------------------------------------------------------------
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Last column and last row index after clamping the configured sizes.
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  always_comb begin
    priority if (frame_width < FRAME_WIDTH_W'(3)) begin
      w_last = COL_W'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(32'(frame_width) - 1);
    end
    priority if (frame_height < FRAME_HEIGHT_W'(3)) begin
      h_last = ROW_W'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(32'(frame_height) - 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake chain. Each stage takes a new beat when empty or when it drains,
  // so a waiting result does not block pixels behind it until the pipe fills.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s1_emit;
  logic s1_last;
  logic s2_valid;
  logic s2_last;
  logic out_valid;

  logic out_free;
  logic s2_leave;
  logic s2_free;
  logic s1_leave;
  logic accept;

  assign out_free     = !out_valid || results.ready;
  assign s2_leave     = s2_valid && out_free;
  assign s2_free      = !s2_valid || out_free;
  // Border pixels never enter stage 2, so they leave stage 1 unconditionally.
  assign s1_leave     = s1_valid && (!s1_emit || s2_free);
  // Hold off pixel beats while reset is applied.
  assign pixels.ready = !rst && (!s1_valid || s1_leave);
  assign accept       = pixels.valid && pixels.ready;

  // ---------------------------------------------------------------------------
  // Raster position of the next pixel.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic             interior;
  logic             frame_end;

  assign interior  = (row_count >= ROW_W'(2)) && (column_count >= COL_W'(2));
  assign frame_end = (row_count == h_last) && (column_count == w_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_wr_en) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (column_count >= w_last) begin
        column_count <= '0;
        row_count    <= (row_count >= h_last) ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line memories are read at the pixel's column on the beat; the
  // pixel and its column wait here for the read data.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]   s1_col;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [PIXEL_W-1:0] top_rd;
  logic [PIXEL_W-1:0] mid_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= column_count;
      s1_pixel <= pixels.pixel;
      s1_emit  <= interior;
      s1_last  <= frame_end;
    end
  end

  // Row two above: read on the beat, rewritten with the row just above.
  sgs_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_top (
    .clk     (clk),
    .wr_en   (s1_leave),
    .wr_addr (s1_col),
    .wr_data (mid_rd),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (top_rd)
  );

  // Row just above: read on the beat, rewritten with the new pixel.
  sgs_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_mid (
    .clk     (clk),
    .wr_en   (s1_leave),
    .wr_addr (s1_col),
    .wr_data (s1_pixel),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (mid_rd)
  );

  // ---------------------------------------------------------------------------
  // Window shift on leaving stage 1; the sums of the shifted window are held
  // in stage 2 so later shifts cannot disturb a stalled result.
  // ---------------------------------------------------------------------------
  col_t  new_col;
  sums_t win_sums;
  sums_t s2_sums;

  assign new_col.top = top_rd;
  assign new_col.mid = mid_rd;
  assign new_col.bot = s1_pixel;

  sgs_window u_window (
    .clk    (clk),
    .rst    (rst),
    .shift  (s1_leave),
    .col_in (new_col),
    .sums   (win_sums)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_leave && s1_emit) begin
      s2_valid <= 1'b1;
    end else if (s2_leave) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_leave && s1_emit) begin
      s2_sums <= win_sums;
      s2_last <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: scale both sums by 1/6, take magnitudes and add them for the edge sum.
  // ---------------------------------------------------------------------------
  logic [GRAD_W-1:0] gv_next;
  logic [GRAD_W-1:0] gh_next;

  assign gv_next = grad_scale(s2_sums.vert);
  assign gh_next = grad_scale(s2_sums.horiz);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_leave) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_leave) begin
      results.grad_vertical   <= gv_next;
      results.grad_horizontal <= gh_next;
      results.edge_sum        <= gv_next + gh_next;
      results.frame_last      <= s2_last;
    end
  end

  assign results.valid = out_valid;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    column_count <= w_last)
    else $error("column counter beyond last column");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (column_count == '0) && (row_count == '0))
    else $error("configuration write did not restart the frame");

  a_interior_tagged: assert property (@(posedge clk) disable iff (rst)
    (accept && interior) |=> (s1_valid && s1_emit))
    else $error("interior pixel not marked for a result");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !out_free) |=> s2_valid && $stable(s2_sums))
    else $error("stage 2 result lost while output stalled");

endmodule
